[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// depends on i_clk and i_rst_n being visible in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ZCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ZCM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ZCM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/zcm_pkg.sv]
// shared types, constants and functions of the zero crossing mask block
// no dependencies
package zcm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int CFG_BITS    = 9;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT    = FIFO_PTR + 1;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // outcome of one pair test
    typedef enum logic [1:0] {
        CR_NONE = 2'd0,
        CR_NB   = 2'd1,
        CR_CUR  = 2'd2
    } t_cross;

    // one line store entry: sample of the row above and its pending mark
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          mark;
    } t_entry;

    // position of an item and its edge flags
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last_row;
        logic                last_col;
    } t_pos;

    // one result item
    typedef struct packed {
        logic                mask_bit;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                frame_end;
        logic                run_last;
    } t_res;

    // size register clamp: zero acts as one, oversize as the maximum
    function automatic logic [CFG_BITS-1:0] zcm_clamp(input logic [CFG_BITS-1:0] v,
                                                      input logic [CFG_BITS-1:0] maxv);
        logic [CFG_BITS-1:0] res;
        if (v == '0) begin
            res = CFG_BITS'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // sign rule of a pair and which element has the smaller magnitude
    function automatic t_cross zcm_cross(input logic signed [SAMPLE_BITS-1:0] cur,
                                         input logic signed [SAMPLE_BITS-1:0] nb);
        logic [SAMPLE_BITS:0] cx;
        logic [SAMPLE_BITS:0] nx;
        logic [SAMPLE_BITS:0] mc;
        logic [SAMPLE_BITS:0] mn;
        logic cur_neg, cur_zero, cur_pos;
        logic nb_neg, nb_zero, nb_pos;
        logic hit;
        t_cross res;
        cx       = {cur[SAMPLE_BITS-1], cur};
        nx       = {nb[SAMPLE_BITS-1], nb};
        mc       = cx[SAMPLE_BITS] ? (~cx + 1'b1) : cx;
        mn       = nx[SAMPLE_BITS] ? (~nx + 1'b1) : nx;
        cur_neg  = cur[SAMPLE_BITS-1];
        cur_zero = (cur == '0);
        cur_pos  = !cur_neg && !cur_zero;
        nb_neg   = nb[SAMPLE_BITS-1];
        nb_zero  = (nb == '0);
        nb_pos   = !nb_neg && !nb_zero;
        hit      = (nb_pos && cur_neg) || (nb_neg && cur_pos) ||
                   (nb_zero && cur_pos) || (nb_pos && cur_zero);
        if (!hit) begin
            res = CR_NONE;
        end else if (mn < mc) begin
            res = CR_NB;
        end else begin
            res = CR_CUR;
        end
        return res;
    endfunction

endpackage

[hw/rtl/zcm_in_if.sv]
// input channel: one field sample per item
// depends on zcm_pkg
interface zcm_in_if
    import zcm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[hw/rtl/zcm_out_if.sv]
// output channel: one mask element per item
// depends on zcm_pkg
interface zcm_out_if
    import zcm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                mask_bit;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                frame_end;
    logic                run_last;

    modport source (output valid, output mask_bit, output row, output col,
                    output frame_end, output run_last, input ready);
    modport sink   (input valid, input mask_bit, input row, input col,
                    input frame_end, input run_last, output ready);
endinterface

[hw/rtl/zcm_line_ram.sv]
// line store: one entry per column, registered read, read before write
// depends on zcm_pkg
module zcm_line_ram
    import zcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [COL_BITS-1:0] i_rd_addr,
    output t_entry              o_rd_data,
    input  logic                i_wr_en,
    input  logic [COL_BITS-1:0] i_wr_addr,
    input  t_entry              i_wr_data
);

    t_entry r_mem [MAX_COLS];
    t_entry r_rd_data;

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/zcm_pos_ctr.sv]
// size registers and raster position counters
// depends on zcm_pkg and assert_macros.svh
`include "assert_macros.svh"
module zcm_pos_ctr
    import zcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_advance,
    output t_pos                o_pos
);

    logic [CFG_BITS-1:0] r_rows, n_rows;
    logic [CFG_BITS-1:0] r_cols, n_cols;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [COL_BITS-1:0] r_col, n_col;
    logic                last_row;
    logic                last_col;

    // edge flags of the current position
    assign last_col = (CFG_BITS'(r_col) + CFG_BITS'(1)) >= r_cols;
    assign last_row = (CFG_BITS'(r_row) + CFG_BITS'(1)) >= r_rows;

    assign o_pos = '{row: r_row, col: r_col, last_row: last_row, last_col: last_col};

    // register writes, clamped on the way in
    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: n_rows = zcm_clamp(i_cfg_data, CFG_BITS'(MAX_ROWS));
                CFG_COLS: n_cols = zcm_clamp(i_cfg_data, CFG_BITS'(MAX_COLS));
                default: begin
                    n_rows = r_rows;
                    n_cols = r_cols;
                end
            endcase
        end
    end

    // raster advance, wrapping at the last column and last row
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_BITS'(MAX_ROWS);
            r_cols <= CFG_BITS'(MAX_COLS);
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    `ZCM_ASSERT_NXT(a_col_wraps, i_advance && last_col && !(i_cfg_we), r_col == '0, "column did not wrap")

endmodule

[hw/rtl/zcm_out_fifo.sv]
// result queue: takes up to two items a cycle, gives one
// depends on zcm_pkg, zcm_out_if and assert_macros.svh
`include "assert_macros.svh"
module zcm_out_fifo
    import zcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  t_res                i_push0,
    input  t_res                i_push1,
    output logic [FIFO_CNT-1:0] o_count,
    zcm_out_if.source           o_res
);

    t_res                r_buf [FIFO_DEPTH];
    logic [FIFO_PTR-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT-1:0] r_count, n_count;
    logic                pop;
    t_res                head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_buf[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR'(i_push_cnt);
        n_rd_ptr = pop ? r_rd_ptr + FIFO_PTR'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CNT'(i_push_cnt) - FIFO_CNT'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage writes
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_buf[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_buf[r_wr_ptr + FIFO_PTR'(1)] <= i_push1;
        end
    end

    assign o_count         = r_count;
    assign o_res.valid     = (r_count != '0);
    assign o_res.mask_bit  = head.mask_bit;
    assign o_res.row       = head.row;
    assign o_res.col       = head.col;
    assign o_res.frame_end = head.frame_end;
    assign o_res.run_last  = head.run_last;

    `ZCM_ASSERT(a_fifo_bound, r_count <= FIFO_CNT'(FIFO_DEPTH), "result queue overflow")

endmodule

[hw/rtl/zero_crossing_mask.sv]
// top level of the zero crossing mask block: pair tests and line store update
// depends on zcm_pkg, zcm_in_if, zcm_out_if, zcm_line_ram, zcm_pos_ctr, zcm_out_fifo
//
//   port       dir   handshake      payload
//   i_item     in    valid/ready    sample (16 bit signed)
//   o_res      out   valid/ready    mask_bit, row, col, frame_end, run_last
//   i_cfg_*    in    write enable   index 0 rows, index 1 cols (9 bit)
//
// one item a cycle while ready is high; the line store read at accept returns the
// row above in the next cycle, where the pair tests run and the store is written
// back. in the last row an item gives two results (one if rows is 1), so the
// one-result-a-cycle output port holds the input back. ready drops unless the
// eight-entry result queue can hold two results each for the item in stage one and a
// new one; reset sets sizes to the maximum, clears positions, queue and valid flags.
`include "assert_macros.svh"
module zero_crossing_mask
    import zcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    zcm_in_if.sink              i_item,
    zcm_out_if.source           o_res
);

    logic                          accept;
    t_pos                          pos;
    t_entry                        ram_rd;
    logic [FIFO_CNT-1:0]           fifo_count;

    // stage one: item whose line store read is in flight
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    t_pos                          r_s1_pos;

    // entry of the previous item, not yet written to the line store
    logic signed [SAMPLE_BITS-1:0] r_lft_sample;
    logic                          r_lft_mark;
    logic [COL_BITS-1:0]           r_lft_addr;
    logic                          r_lft_pend;

    // last write, for a read that met it at the same edge
    logic                          r_fw_valid;
    logic [COL_BITS-1:0]           r_fw_addr;
    t_entry                        r_fw_data;

    t_entry                        above;
    t_cross                        v_cross;
    t_cross                        h_cross;
    logic                          up_mark;
    logic                          cur_mark;
    logic                          left_mark;
    logic                          wr_en;
    logic [COL_BITS-1:0]           wr_addr;
    t_entry                        wr_data;
    t_res                          res_up;
    t_res                          res_cur;
    t_res                          push0;
    t_res                          push1;
    logic [1:0]                    push_cnt;

    // room for the item in stage one and one more, two results each
    assign i_item.ready = (fifo_count + (r_s1_valid ? FIFO_CNT'(2) : FIFO_CNT'(0)))
                          <= FIFO_CNT'(FIFO_DEPTH - 2);
    assign accept = i_item.valid && i_item.ready;

    zcm_pos_ctr u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_advance  (accept),
        .o_pos      (pos)
    );

    zcm_line_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (pos.col),
        .o_rd_data (ram_rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // stage one valid and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_item.sample;
            r_s1_pos    <= pos;
        end
    end

    // row-above entry: pending entry first, then last write, then the store
    always_comb begin
        if (r_lft_pend && (r_lft_addr == r_s1_pos.col)) begin
            above = '{sample: r_lft_sample, mark: r_lft_mark};
        end else if (r_fw_valid && (r_fw_addr == r_s1_pos.col)) begin
            above = r_fw_data;
        end else begin
            above = ram_rd;
        end
    end

    assign v_cross = zcm_cross(above.sample, r_s1_sample);
    assign h_cross = zcm_cross(r_lft_sample, r_s1_sample);

    // vertical and horizontal pair tests
    always_comb begin
        up_mark   = above.mark;
        cur_mark  = 1'b0;
        left_mark = r_lft_mark;
        if ((r_s1_pos.row != '0) && !r_s1_pos.last_col) begin
            case (v_cross)
                CR_NB:   cur_mark = 1'b1;
                CR_CUR:  up_mark  = 1'b1;
                default: up_mark  = above.mark;
            endcase
        end
        if ((r_s1_pos.col != '0) && !r_s1_pos.last_row) begin
            case (h_cross)
                CR_NB:   cur_mark  = 1'b1;
                CR_CUR:  left_mark = 1'b1;
                default: left_mark = r_lft_mark;
            endcase
        end
    end

    // write back the left neighbour, or the tail of the previous row
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_lft_addr;
        wr_data = '{sample: r_lft_sample, mark: r_lft_mark};
        if (r_s1_valid) begin
            if (r_s1_pos.col != '0) begin
                wr_en   = 1'b1;
                wr_addr = r_s1_pos.col - COL_BITS'(1);
                wr_data = '{sample: r_lft_sample, mark: left_mark};
            end else begin
                wr_en = r_lft_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lft_pend <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= wr_en;
            if (r_s1_valid) begin
                r_lft_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= wr_addr;
        r_fw_data <= wr_data;
        if (r_s1_valid) begin
            r_lft_sample <= r_s1_sample;
            r_lft_mark   <= cur_mark;
            r_lft_addr   <= r_s1_pos.col;
        end
    end

    // result items: row above first, then the own element in the last row
    always_comb begin
        res_up  = '{mask_bit:  up_mark,
                    row:       r_s1_pos.row - ROW_BITS'(1),
                    col:       r_s1_pos.col,
                    frame_end: 1'b0,
                    run_last:  !r_s1_pos.last_row};
        res_cur = '{mask_bit:  cur_mark,
                    row:       r_s1_pos.row,
                    col:       r_s1_pos.col,
                    frame_end: r_s1_pos.last_col,
                    run_last:  1'b1};
        push0    = res_cur;
        push1    = res_cur;
        push_cnt = 2'd0;
        if (r_s1_valid) begin
            if (r_s1_pos.row != '0) begin
                push0    = res_up;
                push_cnt = r_s1_pos.last_row ? 2'd2 : 2'd1;
            end else begin
                push_cnt = r_s1_pos.last_row ? 2'd1 : 2'd0;
            end
        end
    end

    zcm_out_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (push0),
        .i_push1    (push1),
        .o_count    (fifo_count),
        .o_res      (o_res)
    );

    `ZCM_ASSERT_NXT(a_s1_follows_accept, accept, r_s1_valid, "accepted item lost")
    `ZCM_ASSERT_IMP(a_left_pending, r_s1_valid && r_s1_pos.col != '0, r_lft_pend, "no left entry")
    `ZCM_ASSERT_IMP(a_queue_room, r_s1_valid, fifo_count <= FIFO_CNT'(FIFO_DEPTH - 2), "queue full")

endmodule
